// ===== rtl/hex_torus_neighbor_index_assert.svh =====
// Assertion macros for the hex torus neighbor index unit
`ifndef HEX_TORUS_NEIGHBOR_INDEX_ASSERT_SVH
`define HEX_TORUS_NEIGHBOR_INDEX_ASSERT_SVH

`ifndef SYNTHESIS
`define HTNI_ASSERT_IMP(lbl, clock, rstn, ante, cons) \
    lbl: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("htni assertion failed");
`define HTNI_ASSERT_NXT(lbl, clock, rstn, ante, cons) \
    lbl: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("htni assertion failed");
`else
`define HTNI_ASSERT_IMP(lbl, clock, rstn, ante, cons)
`define HTNI_ASSERT_NXT(lbl, clock, rstn, ante, cons)
`endif

`endif

// ===== rtl/htni_pkg.sv =====
// Shared types, constants and direction tables of the hex torus neighbor unit
package htni_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int CFG_W      = 9;
    localparam int IDX_W      = 16;
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int BIT_POS_W  = (ROW_W > 1) ? $clog2(ROW_W) : 1;
    localparam int HX_W       = COL_W + 3;
    localparam int HY_W       = ROW_W + 2;

    typedef enum logic [2:0] {
        DIR_RIGHT      = 3'd0,
        DIR_RIGHT_UP   = 3'd1,
        DIR_LEFT_UP    = 3'd2,
        DIR_LEFT       = 3'd3,
        DIR_LEFT_DOWN  = 3'd4,
        DIR_RIGHT_DOWN = 3'd5
    } dir_t;

    typedef enum logic {
        CMD_NEIGHBOR  = 1'b0,
        CMD_DIRECTION = 1'b1
    } cmd_t;

    typedef enum logic {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } reg_idx_t;

    // one item as it walks down the divider chain; both indices are divided side by side
    typedef struct packed {
        cmd_t              cmd;
        logic [2:0]        dir;
        logic              from_in;
        logic              to_in;
        logic [IDX_W-1:0]  from_rem;
        logic [IDX_W-1:0]  to_rem;
        logic [ROW_W-1:0]  from_q;
        logic [ROW_W-1:0]  to_q;
    } div_item_t;

    // hand-off from the hex step stage to the output stage
    typedef struct packed {
        logic              nb_valid;
        logic [ROW_W-1:0]  hy;
        logic [COL_W-1:0]  ncol;
        logic [2:0]        dir_out;
        logic [2:0]        opposite_dir;
        logic              result_valid;
    } step_res_t;

    function automatic logic dir_ok(input logic [2:0] d);
        return (d <= 3'(DIR_RIGHT_DOWN));
    endfunction

    function automatic logic signed [2:0] step_dx(input logic [2:0] d);
        logic signed [2:0] r;
        unique case (d)
            DIR_RIGHT:      r = 3'sd2;
            DIR_RIGHT_UP:   r = 3'sd1;
            DIR_LEFT_UP:    r = -3'sd1;
            DIR_LEFT:       r = -3'sd2;
            DIR_LEFT_DOWN:  r = -3'sd1;
            DIR_RIGHT_DOWN: r = 3'sd1;
            default:        r = 3'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [1:0] step_dy(input logic [2:0] d);
        logic signed [1:0] r;
        unique case (d)
            DIR_RIGHT:      r = 2'sd0;
            DIR_RIGHT_UP:   r = 2'sd1;
            DIR_LEFT_UP:    r = 2'sd1;
            DIR_LEFT:       r = 2'sd0;
            DIR_LEFT_DOWN:  r = -2'sd1;
            DIR_RIGHT_DOWN: r = -2'sd1;
            default:        r = 2'sd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] opp_dir(input logic [2:0] d);
        logic [2:0] r;
        unique case (d)
            DIR_RIGHT:      r = DIR_LEFT;
            DIR_RIGHT_UP:   r = DIR_LEFT_DOWN;
            DIR_LEFT_UP:    r = DIR_RIGHT_DOWN;
            DIR_LEFT:       r = DIR_RIGHT;
            DIR_LEFT_DOWN:  r = DIR_RIGHT_UP;
            DIR_RIGHT_DOWN: r = DIR_LEFT_UP;
            default:        r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/htni_div_cell.sv =====
// One cell of the divider chain: one quotient bit for both cell indices
module htni_div_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [htni_pkg::BIT_POS_W-1:0] bit_pos,
    input  logic [htni_pkg::CFG_W-1:0]    width,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  htni_pkg::div_item_t           in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output htni_pkg::div_item_t           out_item
);
    import htni_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    div_item_t          item_reg;
    div_item_t          item_next;
    logic [IDX_W:0]     divisor;
    logic               from_ge;
    logic               to_ge;

    assign divisor  = (IDX_W + 1)'(width) << bit_pos;
    assign from_ge  = {1'b0, in_item.from_rem} >= divisor;
    assign to_ge    = {1'b0, in_item.to_rem} >= divisor;
    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        item_next          = in_item;
        item_next.from_rem = from_ge ? in_item.from_rem - divisor[IDX_W-1:0] : in_item.from_rem;
        item_next.to_rem   = to_ge ? in_item.to_rem - divisor[IDX_W-1:0] : in_item.to_rem;
        item_next.from_q   = {in_item.from_q[ROW_W-2:0], from_ge};
        item_next.to_q     = {in_item.to_q[ROW_W-2:0], to_ge};
        valid_next         = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== rtl/htni_hex_step.sv =====
// Hex coordinate stage: neighbor step with wrap, or direction between two cells
module htni_hex_step (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [htni_pkg::CFG_W-1:0] width,
    input  logic [htni_pkg::CFG_W-1:0] height,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  htni_pkg::div_item_t        in_item,
    output logic                       out_valid,
    input  logic                       out_ready,
    output htni_pkg::step_res_t        out_res
);
    import htni_pkg::*;

    logic                    valid_reg;
    logic                    valid_next;
    step_res_t               res_reg;
    step_res_t               res_next;

    logic [COL_W:0]          fx;
    logic [COL_W:0]          tx;
    logic signed [HX_W-1:0]  w2;
    logic signed [HY_W-1:0]  hs;
    logic signed [HX_W-1:0]  hx_raw;
    logic signed [HX_W-1:0]  hx_wrap;
    logic signed [HY_W-1:0]  hy_raw;
    logic signed [HY_W-1:0]  hy_wrap;
    logic signed [HX_W-1:0]  dx;
    logic signed [HY_W-1:0]  dy;
    logic                    from_ok;
    logic                    to_ok;
    logic                    d_ok;
    logic                    row_same;
    logic                    row_up;
    logic                    row_down;
    logic                    col_r2;
    logic                    col_l2;
    logic                    col_r1;
    logic                    col_l1;

    // doubled column axis: odd rows sit half a cell to the right
    assign fx = {in_item.from_rem[COL_W-1:0], 1'b0} + (COL_W + 1)'(in_item.from_q[0]);
    assign tx = {in_item.to_rem[COL_W-1:0], 1'b0} + (COL_W + 1)'(in_item.to_q[0]);
    assign w2 = $signed({1'b0, width, 1'b0});
    assign hs = $signed(HY_W'(height));

    assign from_ok = in_item.from_in && ({1'b0, in_item.from_q} < height);
    assign to_ok   = in_item.to_in && ({1'b0, in_item.to_q} < height);
    assign d_ok    = dir_ok(in_item.dir);

    always_comb
    begin
        hx_raw = $signed(HX_W'(fx)) + HX_W'(step_dx(in_item.dir));
        hy_raw = $signed(HY_W'(in_item.from_q)) + HY_W'(step_dy(in_item.dir));
        if (hx_raw >= w2)
            hx_wrap = hx_raw - w2;
        else if (hx_raw < 0)
            hx_wrap = hx_raw + w2;
        else
            hx_wrap = hx_raw;
        if (hy_raw >= hs)
            hy_wrap = hy_raw - hs;
        else if (hy_raw < 0)
            hy_wrap = hy_raw + hs;
        else
            hy_wrap = hy_raw;
    end

    assign dx = $signed(HX_W'(tx)) - $signed(HX_W'(fx));
    assign dy = $signed(HY_W'(in_item.to_q)) - $signed(HY_W'(in_item.from_q));

    // wrapped differences count as adjacent too
    assign row_same = (dy == 0);
    assign row_up   = (dy == 1) || (dy == 1 - hs);
    assign row_down = (dy == -1) || (dy == hs - 1);
    assign col_r2   = (dx == 2) || (dx == 2 - w2);
    assign col_l2   = (dx == -2) || (dx == w2 - 2);
    assign col_r1   = (dx == 1) || (dx == 1 - w2);
    assign col_l1   = (dx == -1) || (dx == w2 - 1);

    always_comb
    begin
        res_next              = '0;
        res_next.opposite_dir = opp_dir(in_item.dir);
        res_next.hy           = hy_wrap[ROW_W-1:0];
        res_next.ncol         = hx_wrap[COL_W:1];
        if (in_item.cmd == CMD_NEIGHBOR)
        begin
            res_next.nb_valid     = d_ok && from_ok;
            res_next.result_valid = d_ok && from_ok;
        end
        else if (from_ok && to_ok)
        begin
            res_next.result_valid = 1'b1;
            priority if (row_same && col_r2)
                res_next.dir_out = DIR_RIGHT;
            else if (row_same && col_l2)
                res_next.dir_out = DIR_LEFT;
            else if (row_same)
                res_next.result_valid = 1'b0;
            else if (row_up && col_r1)
                res_next.dir_out = DIR_RIGHT_UP;
            else if (row_up && col_l1)
                res_next.dir_out = DIR_LEFT_UP;
            else if (row_up)
                res_next.result_valid = 1'b0;
            else if (row_down && col_r1)
                res_next.dir_out = DIR_RIGHT_DOWN;
            else if (row_down && col_l1)
                res_next.dir_out = DIR_LEFT_DOWN;
            else
                res_next.result_valid = 1'b0;
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

// ===== rtl/hex_torus_neighbor_index.sv =====
// Top level of the hex torus neighbor index unit
// Takes one beat per clock while the output is not stalled and gives one result beat per input
// beat, in order. A chain of ROW_W divider cells splits both cell indices into row and column
// one quotient bit per cell, one stage forms the hex step or direction, and the output
// register forms the row-major neighbor index with one multiply. Every stage holds its beat
// while the next one is full, so the chain fills up behind a stalled output and keeps taking
// beats until all stages hold one. Grid width and height are clamped to 1..256; write them
// only while no beat is in flight.
module hex_torus_neighbor_index (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [htni_pkg::CFG_W-1:0] cfg_data,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [39:0]                s_tdata,   // from_cell, to_cell, dir_in, zero pad
    input  logic                       s_tuser,   // cmd
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [23:0]                m_tdata,   // neighbor_cell, dir_out, opposite_dir, pad
    output logic                       m_tuser    // result_valid
);
    import htni_pkg::*;

    `include "hex_torus_neighbor_index_assert.svh"

    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    logic [CFG_W-1:0]   eff_width;
    logic [CFG_W-1:0]   eff_height;

    div_item_t          chain_item  [ROW_W+1];
    logic               chain_valid [ROW_W+1];
    logic               chain_ready [ROW_W+1];

    logic               step_valid;
    logic               step_ready;
    step_res_t          step_res;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [IDX_W-1:0]   nb_reg;
    logic [IDX_W-1:0]   nb_next;
    logic [2:0]         dout_reg;
    logic [2:0]         opp_reg;
    logic               rv_reg;
    logic [IDX_W:0]     nb_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(10);
            height_reg <= CFG_W'(10);
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_GRID_WIDTH:  width_reg  <= cfg_data;
                REG_GRID_HEIGHT: height_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == '0)
            eff_width = CFG_W'(1);
        else if (width_reg > CFG_W'(MAX_WIDTH))
            eff_width = CFG_W'(MAX_WIDTH);
        else
            eff_width = width_reg;
        if (height_reg == '0)
            eff_height = CFG_W'(1);
        else if (height_reg > CFG_W'(MAX_HEIGHT))
            eff_height = CFG_W'(MAX_HEIGHT);
        else
            eff_height = height_reg;
    end

    // an index below width << ROW_W divides exactly into ROW_W quotient bits
    assign chain_item[0].cmd      = cmd_t'(s_tuser);
    assign chain_item[0].dir      = s_tdata[34:32];
    assign chain_item[0].from_rem = s_tdata[15:0];
    assign chain_item[0].to_rem   = s_tdata[31:16];
    assign chain_item[0].from_q   = '0;
    assign chain_item[0].to_q     = '0;
    assign chain_item[0].from_in  = {1'b0, s_tdata[15:ROW_W]} < (IDX_W - ROW_W + 1)'(eff_width);
    assign chain_item[0].to_in    = {1'b0, s_tdata[31:16+ROW_W]} < (IDX_W - ROW_W + 1)'(eff_width);
    assign chain_valid[0]         = s_tvalid;

    assign s_tready = chain_ready[0];

    for (genvar i = 0; i < ROW_W; i++)
    begin : g_cell
        htni_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .bit_pos   (BIT_POS_W'(ROW_W - 1 - i)),
            .width     (eff_width),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_item   (chain_item[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_item  (chain_item[i+1])
        );
    end

    htni_hex_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .width     (eff_width),
        .height    (eff_height),
        .in_valid  (chain_valid[ROW_W]),
        .in_ready  (chain_ready[ROW_W]),
        .in_item   (chain_item[ROW_W]),
        .out_valid (step_valid),
        .out_ready (step_ready),
        .out_res   (step_res)
    );

    // output register: row * width + column
    assign nb_sum         = (IDX_W + 1)'(step_res.hy) * (IDX_W + 1)'(eff_width)
                            + (IDX_W + 1)'(step_res.ncol);
    assign nb_next        = step_res.nb_valid ? nb_sum[IDX_W-1:0] : '0;
    assign step_ready     = !out_valid_reg || m_tready;
    assign out_valid_next = step_ready ? step_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_ready && step_valid)
        begin
            nb_reg   <= nb_next;
            dout_reg <= step_res.dir_out;
            opp_reg  <= step_res.opposite_dir;
            rv_reg   <= step_res.result_valid;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, opp_reg, dout_reg, nb_reg};
    assign m_tuser  = rv_reg;

    // a result carries either a neighbor index or a direction, never both
    `HTNI_ASSERT_IMP(a_nb_dir_excl, clk, rst_n, m_tvalid && |m_tdata[15:0], m_tdata[18:16] == '0)
    // opposite direction is always a legal code
    `HTNI_ASSERT_IMP(a_opp_legal, clk, rst_n, m_tvalid, m_tdata[21:19] <= 3'(DIR_RIGHT_DOWN))
    // with the output empty, the whole chain passes ready through to the input
    `HTNI_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !m_tvalid, s_tready)
    // an invalid result never carries a neighbor index
    `HTNI_ASSERT_IMP(a_invalid_zero, clk, rst_n, m_tvalid && !m_tuser, m_tdata[15:0] == '0)

endmodule

// ===== bench/tb_hex_torus_neighbor_index.sv =====
// Testbench for the hex torus neighbor index unit: predicted results against streamed results
`timescale 1ns / 100ps

module tb_hex_torus_neighbor_index;
    import htni_pkg::*;

    localparam int LATENCY      = ROW_W + 2;
    localparam int SETTLE       = LATENCY + 4;
    localparam int STALL_LIMIT  = 5000;
    localparam int REPORT_MAX   = 10;
    localparam logic [2:0] DIR_BAD_LO = 3'd6;
    localparam logic [2:0] DIR_BAD_HI = 3'd7;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic        cmd;
        logic [15:0] from_cell;
        logic [15:0] to_cell;
        logic [2:0]  dir_in;
    } hex_query_t;

    typedef struct packed {
        logic [15:0] nbr;
        logic [2:0]  dout;
        logic [2:0]  opp;
        logic        ok;
    } hex_answer_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic              cfg_index = 1'b0;
    logic [CFG_W-1:0]  cfg_data = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [39:0]       s_tdata = '0;
    logic              s_tuser = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [23:0]       m_tdata;
    logic              m_tuser;

    hex_query_t   query_q [$];
    hex_answer_t  answer_q [$];
    logic [8:0]   width_reg = 9'd10;
    logic [8:0]   height_reg = 9'd10;
    idle_mode_t   idle_mode = IDLE_NONE;
    int           mismatch_count = 0;
    int           result_count = 0;
    int           quiet_cycles = 0;

    hex_torus_neighbor_index u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic int grid_w();
        if (width_reg == 0)
            return 1;
        if (width_reg > MAX_WIDTH)
            return MAX_WIDTH;
        return int'(width_reg);
    endfunction

    function automatic int grid_h();
        if (height_reg == 0)
            return 1;
        if (height_reg > MAX_HEIGHT)
            return MAX_HEIGHT;
        return int'(height_reg);
    endfunction

    // expected answer for one query under the current grid size
    function automatic hex_answer_t hex_predict(hex_query_t q);
        int w;
        int h;
        int cells;
        int from_i;
        int to_i;
        int fx;
        int fy;
        int tx;
        int ty;
        int dx;
        int dy;
        int found;
        hex_answer_t a;
        w = grid_w();
        h = grid_h();
        cells = w * h;
        from_i = int'(q.from_cell);
        to_i = int'(q.to_cell);
        a = '0;
        if (q.dir_in <= DIR_RIGHT_DOWN)
            a.opp = 3'((int'(q.dir_in) + 3) % 6);
        fy = from_i / w;
        fx = (from_i % w) * 2 + (fy & 1);
        if (q.cmd == CMD_NEIGHBOR)
        begin
            if (q.dir_in <= DIR_RIGHT_DOWN && from_i < cells)
            begin
                case (q.dir_in)
                    DIR_RIGHT:      fx = fx + 2;
                    DIR_RIGHT_UP:   begin fx = fx + 1; fy = fy + 1; end
                    DIR_LEFT_UP:    begin fx = fx - 1; fy = fy + 1; end
                    DIR_LEFT:       fx = fx - 2;
                    DIR_LEFT_DOWN:  begin fx = fx - 1; fy = fy - 1; end
                    default:        begin fx = fx + 1; fy = fy - 1; end
                endcase
                if (fx >= 2 * w)
                    fx = fx - 2 * w;
                else if (fx < 0)
                    fx = fx + 2 * w;
                if (fy >= h)
                    fy = fy - h;
                else if (fy < 0)
                    fy = fy + h;
                a.nbr = 16'(fy * w + fx / 2);
                a.ok = 1'b1;
            end
        end
        else if (from_i < cells && to_i < cells)
        begin
            ty = to_i / w;
            tx = (to_i % w) * 2 + (ty & 1);
            dx = tx - fx;
            dy = ty - fy;
            found = -1;
            // row test order is same, up, down; column order is right, left
            if (dy == 0)
            begin
                if (dx == 2 || dx == (1 - w) * 2)
                    found = DIR_RIGHT;
                else if (dx == -2 || dx == (w - 1) * 2)
                    found = DIR_LEFT;
            end
            else if (dy == 1 || dy == 1 - h)
            begin
                if (dx == 1 || dx == 1 - 2 * w)
                    found = DIR_RIGHT_UP;
                else if (dx == -1 || dx == 2 * w - 1)
                    found = DIR_LEFT_UP;
            end
            else if (dy == -1 || dy == h - 1)
            begin
                if (dx == 1 || dx == 1 - 2 * w)
                    found = DIR_RIGHT_DOWN;
                else if (dx == -1 || dx == 2 * w - 1)
                    found = DIR_LEFT_DOWN;
            end
            if (found >= 0)
            begin
                a.dout = 3'(found);
                a.ok = 1'b1;
            end
        end
        return a;
    endfunction

    // random query, mostly in-grid and adjacent pairs, some out of grid and raw noise
    function automatic hex_query_t make_query();
        int cells;
        int roll;
        hex_query_t q;
        hex_query_t probe;
        hex_answer_t nb;
        cells = grid_w() * grid_h();
        roll = $urandom_range(0, 99);
        q.cmd = CMD_NEIGHBOR;
        q.from_cell = 16'($urandom_range(0, cells - 1));
        q.to_cell = 16'($urandom_range(0, cells - 1));
        q.dir_in = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                               : 3'($urandom_range(0, 5));
        if (roll < 40)
        begin
            q.cmd = CMD_NEIGHBOR;
        end
        else if (roll < 75)
        begin
            probe = q;
            probe.cmd = CMD_NEIGHBOR;
            probe.dir_in = 3'($urandom_range(0, 5));
            nb = hex_predict(probe);
            q.cmd = CMD_DIRECTION;
            q.to_cell = nb.nbr;
            q.dir_in = 3'($urandom_range(0, 7));
        end
        else if (roll < 85)
        begin
            q.cmd = CMD_DIRECTION;
            if ($urandom_range(0, 2) == 0)
                q.to_cell = q.from_cell;
        end
        else if (roll < 95)
        begin
            q.cmd = 1'($urandom_range(0, 1));
            if (cells <= 65535)
            begin
                if ($urandom_range(0, 1) == 0)
                    q.from_cell = 16'($urandom_range(cells, 65535));
                else
                    q.to_cell = 16'($urandom_range(cells, 65535));
            end
        end
        else
        begin
            q = {4'($urandom), 32'($urandom)};
            q.from_cell = 16'($urandom);
        end
        return q;
    endfunction

    task automatic add_query(logic cmd, int from_i, int to_i, logic [2:0] dir);
        hex_query_t q;
        q.cmd = cmd;
        q.from_cell = 16'(from_i);
        q.to_cell = 16'(to_i);
        q.dir_in = dir;
        query_q.push_back(q);
    endtask

    task automatic write_reg(reg_idx_t idx, int value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(value);
        if (idx == REG_GRID_WIDTH)
            width_reg = 9'(value);
        else
            height_reg = 9'(value);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (query_q.size() != 0 || s_tvalid || answer_q.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic run_phase(int w, int h, idle_mode_t mode, int n, bit hold_midway);
        write_reg(REG_GRID_WIDTH, w);
        write_reg(REG_GRID_HEIGHT, h);
        @(posedge clk);
        cfg_we <= 1'b0;
        idle_mode <= mode;
        @(negedge clk);
        for (int i = 0; i < n; i++)
        begin
            // sender holds off until the block has drained
            if (hold_midway && i == n / 2)
            begin
                wait_idle();
                @(negedge clk);
            end
            query_q.push_back(make_query());
        end
        wait_idle();
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin : drive_queries
        hex_query_t q;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (query_q.size() != 0 &&
                !((idle_mode == IDLE_SENDER && $urandom_range(0, 99) < 87) ||
                  (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 18)))
            begin
                q = query_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {5'b0, q.dir_in, q.to_cell, q.from_cell};
                s_tuser <= q.cmd;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !((idle_mode == IDLE_RECEIVER && $urandom_range(0, 99) < 87) ||
                          (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 18));
    end

    // predict on each input beat, check each output beat
    always @(posedge clk)
    begin : check_results
        hex_query_t q;
        hex_answer_t exp_a;
        hex_answer_t got_a;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                q.cmd = s_tuser;
                q.from_cell = s_tdata[15:0];
                q.to_cell = s_tdata[31:16];
                q.dir_in = s_tdata[34:32];
                answer_q.push_back(hex_predict(q));
            end
            if (m_tvalid && m_tready)
            begin
                got_a.nbr = m_tdata[15:0];
                got_a.dout = m_tdata[18:16];
                got_a.opp = m_tdata[21:19];
                got_a.ok = m_tuser;
                if (answer_q.size() == 0)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= REPORT_MAX)
                        $display("ERROR: result beat %0d arrived with nothing pending",
                                 result_count);
                end
                else
                begin
                    exp_a = answer_q.pop_front();
                    if (got_a !== exp_a)
                    begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= REPORT_MAX)
                            $display({"ERROR: result beat %0d: exp nbr=%0d dir=%0d opp=%0d ",
                                      "ok=%0d, got nbr=%0d dir=%0d opp=%0d ok=%0d"},
                                     result_count, exp_a.nbr, exp_a.dout, exp_a.opp,
                                     exp_a.ok, got_a.nbr, got_a.dout, got_a.opp, got_a.ok);
                    end
                end
                result_count = result_count + 1;
            end
        end
    end

    // watchdog on cycles with work pending but no beat moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else if (query_q.size() != 0 || s_tvalid || answer_q.size() != 0)
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed beats at the reset grid of 10 by 10
        for (int d = 0; d < 6; d++)
            add_query(CMD_NEIGHBOR, 0, 0, 3'(d));
        add_query(CMD_NEIGHBOR, 99, 0, DIR_RIGHT);
        add_query(CMD_NEIGHBOR, 99, 0, DIR_RIGHT_UP);
        add_query(CMD_NEIGHBOR, 99, 0, DIR_RIGHT_DOWN);
        add_query(CMD_NEIGHBOR, 9, 0, DIR_RIGHT);
        add_query(CMD_NEIGHBOR, 90, 0, DIR_LEFT_DOWN);
        add_query(CMD_NEIGHBOR, 5, 0, DIR_BAD_LO);
        add_query(CMD_NEIGHBOR, 5, 0, DIR_BAD_HI);
        add_query(CMD_NEIGHBOR, 100, 0, DIR_RIGHT);
        add_query(CMD_NEIGHBOR, 65535, 0, DIR_LEFT);
        add_query(CMD_DIRECTION, 0, 1, DIR_LEFT);
        add_query(CMD_DIRECTION, 0, 9, DIR_RIGHT_UP);
        add_query(CMD_DIRECTION, 0, 10, DIR_LEFT_UP);
        add_query(CMD_DIRECTION, 0, 90, DIR_LEFT_DOWN);
        add_query(CMD_DIRECTION, 5, 5, DIR_RIGHT_DOWN);
        add_query(CMD_DIRECTION, 0, 55, DIR_RIGHT);
        add_query(CMD_DIRECTION, 0, 100, DIR_RIGHT);
        add_query(CMD_DIRECTION, 100, 0, DIR_RIGHT);
        add_query(CMD_DIRECTION, 65535, 65535, DIR_BAD_HI);
        add_query(CMD_DIRECTION, 11, 1, DIR_BAD_LO);
        for (int i = 0; i < 30; i++)
            query_q.push_back(make_query());
        wait_idle();

        run_phase(256, 256, IDLE_SENDER, 60, 1'b0);
        run_phase(1, 2, IDLE_RECEIVER, 50, 1'b0);
        run_phase(0, 0, IDLE_BOTH, 40, 1'b0);
        run_phase(511, 511, IDLE_NONE, 60, 1'b1);
        run_phase(7, 5, IDLE_SENDER, 50, 1'b0);
        run_phase(2, 2, IDLE_RECEIVER, 50, 1'b0);
        run_phase(33, 18, IDLE_BOTH, 60, 1'b0);
        run_phase(256, 2, IDLE_NONE, 50, 1'b0);
        run_phase(1, 256, IDLE_SENDER, 50, 1'b0);
        run_phase(300, 3, IDLE_RECEIVER, 50, 1'b0);
        run_phase(16, 16, IDLE_BOTH, 60, 1'b0);
        run_phase($urandom_range(1, 256), $urandom_range(1, 128) * 2, IDLE_NONE, 40, 1'b0);

        if (answer_q.size() != 0)
            mismatch_count = mismatch_count + answer_q.size();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/htni_pkg.sv
rtl/htni_div_cell.sv
rtl/htni_hex_step.sv
rtl/hex_torus_neighbor_index.sv
bench/tb_hex_torus_neighbor_index.sv
